@@ hw/rtl/fufr_pkg.sv @@
// fufr_pkg: shared types, codes and constants of the firmware upgrade frame receiver
// used by fufr_ctrl, fufr_dp and firmware_upgrade_frame_receiver
package fufr_pkg;

   localparam int unsigned PAYLOAD_BYTES_DEF = 128;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
   localparam logic [31:0] BASE_DEF = 32'h08000000;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_TIMEOUT = 2'd1,
      KIND_START   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_RECV     = 3'd1,
      ST_SUCCESS  = 3'd2,
      ST_FAILED   = 3'd3,
      ST_ABORTED  = 3'd4,
      ST_TIMEDOUT = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      RSP_OK   = 3'd0,
      RSP_LEN  = 3'd1,
      RSP_SIZE = 3'd2,
      RSP_DONE = 3'd3,
      RSP_CRC  = 3'd4
   } rsp_type;

   typedef enum logic [1:0] {
      FC_NONE    = 2'd0,
      FC_DATA    = 2'd1,
      FC_END     = 2'd2,
      FC_UNKNOWN = 2'd3
   } fcmd_type;

   // register indexes
   localparam logic [2:0] REG_DATA_CODE  = 3'd0;
   localparam logic [2:0] REG_END_CODE   = 3'd1;
   localparam logic [2:0] REG_ABORT_CODE = 3'd2;
   localparam logic [2:0] REG_BASE       = 3'd3;
   localparam logic [2:0] REG_TIMEOUT    = 3'd4;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_CRC,
      FSM_DRAIN,
      FSM_RESP
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic take;       // latch the item and run its byte/timeout/start step
      logic crc_step;   // one bit of the crc shift
      logic drain_next; // a word transfer left, advance drain index
      logic commit;     // commit address, length and crc of the data frame
      logic finish;     // clear frame after the response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_crc;   // the step took a payload byte into the crc
      logic frame_done; // the step completed a frame that gives a response
      logic data_ok;    // completed frame is a good data frame
      logic words_left; // more payload words to drain
      logic quiet;      // step gives a status-only result
      logic silent;     // step gives no result at all
   } sts_type;

endpackage

@@ hw/rtl/firmware_upgrade_frame_receiver.sv @@
// sequence: a byte step is taken while idle; a byte that enters the crc is then shifted
// in one bit per cycle, then the payload words of a good data frame and the response
// are sent; a new item is stalled until the previous one is fully handled
// reset: synchronous active high; registers return to their reset codes,
// session idle, address at the default image base
module firmware_upgrade_frame_receiver #(
   parameter int unsigned PAYLOAD_BYTES = fufr_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_valid,
   output logic [31:0] rsp_write_address,
   output logic [31:0] rsp_write_word,
   output logic        rsp_response_valid,
   output logic [2:0]  rsp_response_code,
   output logic [2:0]  rsp_session_status,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fufr_pkg::*;

   logic [7:0]  dcode_ff, ecode_ff, acode_ff;
   logic [31:0] base_ff;
   logic [3:0]  tlim_ff;
   logic        wr;
   cmd_type     cmd;
   sts_type     sts;
   logic        is_w, is_r, lst;
   logic [31:0] w_a, w_d;
   logic [2:0]  r_c, s_s;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dcode_ff <= 8'd1; ecode_ff <= 8'd2; acode_ff <= 8'd3;
         base_ff <= BASE_DEF; tlim_ff <= 4'd10;
      end else if (wr) begin
         case (csr_paddr[4:2])
            REG_DATA_CODE:  dcode_ff <= csr_pwdata[7:0];
            REG_END_CODE:   ecode_ff <= csr_pwdata[7:0];
            REG_ABORT_CODE: acode_ff <= csr_pwdata[7:0];
            REG_BASE:       base_ff <= csr_pwdata;
            REG_TIMEOUT:    tlim_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_DATA_CODE:  csr_prdata = {24'd0, dcode_ff};
         REG_END_CODE:   csr_prdata = {24'd0, ecode_ff};
         REG_ABORT_CODE: csr_prdata = {24'd0, acode_ff};
         REG_BASE:       csr_prdata = base_ff;
         REG_TIMEOUT:    csr_prdata = {28'd0, tlim_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   fufr_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .o_is_write(is_w), .o_is_resp(is_r), .o_last(lst), .sts, .cmd
   );

   fufr_dp #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_dp (
      .clock, .reset, .cmd, .sts, .req_kind, .req_rx_byte,
      .data_code(dcode_ff), .end_code(ecode_ff), .abort_code(acode_ff),
      .base_address(base_ff), .timeout_limit(tlim_ff),
      .o_write_address(w_a), .o_write_word(w_d),
      .o_response_code(r_c), .o_session_status(s_s)
   );

   // result fields, zero where not carried
   assign rsp_write_valid    = is_w;
   assign rsp_write_address  = is_w ? w_a : 32'd0;
   assign rsp_write_word     = is_w ? w_d : 32'd0;
   assign rsp_response_valid = is_r;
   assign rsp_response_code  = is_r ? r_c : 3'd0;
   assign rsp_session_status = s_s;
   assign rsp_last           = lst;

endmodule

@@ hw/rtl/fufr_dp.sv @@
// fufr_dp: frame parse state, payload word store, crc and result fields
// depends on fufr_pkg
module fufr_dp #(
   parameter int unsigned PAYLOAD_BYTES = fufr_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  fufr_pkg::cmd_type   cmd,
   output fufr_pkg::sts_type   sts,
   input  logic [1:0]          req_kind,
   input  logic [7:0]          req_rx_byte,
   input  logic [7:0]          data_code,
   input  logic [7:0]          end_code,
   input  logic [7:0]          abort_code,
   input  logic [31:0]         base_address,
   input  logic [3:0]          timeout_limit,
   output logic [31:0]         o_write_address,
   output logic [31:0]         o_write_word,
   output logic [2:0]          o_response_code,
   output logic [2:0]          o_session_status
);
   import fufr_pkg::*;

   localparam int unsigned WORDS = PAYLOAD_BYTES / 4;
   localparam int unsigned WA = (WORDS > 1) ? $clog2(WORDS) : 1;

   status_type  phase_ff, phase_in;
   logic [8:0]  pos_ff, pos_in;
   fcmd_type    fcmd_ff, fcmd_in;
   logic [7:0]  flen_ff, flen_in;
   logic        lok_ff, lok_in;
   logic [63:0] endf_ff, endf_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] ccrc_ff, ccrc_in;
   logic [31:0] fcrc_ff, fcrc_in;
   logic [3:0]  tcnt_ff, tcnt_in;
   logic [WA-1:0] drn_ff, drn_in;
   logic [2:0]  code_ff, code_in;
   logic [31:0] wword_ff;
   logic [31:0] store [WORDS];

   // step classification on the incoming item
   logic        recv, is_byte, is_to, is_start;
   logic        done_data, done_end, wr_store;
   logic [8:0]  p2;
   logic [WA-1:0] wsel;
   logic [8:0]  flim;
   logic [7:0]  b;
   logic        len_good;

   always_comb begin
      b        = req_rx_byte;
      recv     = (phase_ff == ST_RECV);
      is_start = (req_kind == KIND_START);
      is_to    = recv && (req_kind == KIND_TIMEOUT);
      is_byte  = recv && (req_kind == KIND_BYTE);
      p2       = pos_ff - 9'd2;
      wsel     = p2[WA+1:2];
      len_good = (b != 8'd0) && ({1'b0, b} <= 9'(PAYLOAD_BYTES)) && (b[1:0] == 2'b00);
      flim     = {1'b0, ((pos_ff == 9'd1) ? b : flen_ff)} + 9'd2;
      wr_store = is_byte && (fcmd_ff == FC_DATA) && (pos_ff >= 9'd2) && lok_ff
                 && ({2'b00, p2[8:2]} < 9'(WORDS));
      done_data = is_byte && (pos_ff != 9'd0) && (fcmd_ff == FC_DATA)
                  && ((pos_ff + 9'd1) >= flim);
      done_end  = is_byte && (pos_ff != 9'd0) && (fcmd_ff == FC_END)
                  && ((pos_ff + 9'd1) >= 9'd9);
   end

   // status to the controller
   always_comb begin
      sts.need_crc   = wr_store;
      sts.frame_done = done_data || done_end
                       || (is_byte && pos_ff == 9'd0 && b == abort_code);
      sts.data_ok    = done_data && ((pos_ff == 9'd1) ? len_good : lok_ff);
      sts.words_left = (9'(drn_ff) + 9'd1) < {3'b000, flen_ff[7:2]};
      sts.quiet      = is_to && ((tcnt_ff + 4'd1) >= timeout_limit);
      sts.silent     = !sts.frame_done && !sts.quiet;
   end

   // next state of the frame parser and session
   always_comb begin
      logic [31:0] c;
      logic [31:0] hcrc, hsize;
      phase_in = phase_ff; pos_in = pos_ff; fcmd_in = fcmd_ff; flen_in = flen_ff;
      lok_in = lok_ff; endf_in = endf_ff; addr_in = addr_ff; total_in = total_ff;
      ccrc_in = ccrc_ff; fcrc_in = fcrc_ff; tcnt_in = tcnt_ff;
      drn_in = drn_ff; code_in = code_ff;
      c = fcrc_ff;
      hcrc = 32'd0; hsize = 32'd0;
      if (cmd.take) begin
         drn_in = '0;
         if (is_start) begin
            phase_in = ST_RECV; addr_in = base_address; total_in = 32'd0;
            ccrc_in = CRC_INIT; tcnt_in = 4'd0; pos_in = 9'd0; fcmd_in = FC_NONE;
            flen_in = 8'd0; lok_in = 1'b0; endf_in = 64'd0; fcrc_in = CRC_INIT;
         end else if (is_to) begin
            pos_in = 9'd0; fcmd_in = FC_NONE; flen_in = 8'd0; lok_in = 1'b0;
            endf_in = 64'd0; fcrc_in = ccrc_ff;
            tcnt_in = tcnt_ff + 4'd1;
            if (sts.quiet) phase_in = ST_TIMEDOUT;
         end else if (is_byte) begin
            if (pos_ff == 9'd0) begin
               pos_in = 9'd1;
               fcrc_in = ccrc_ff;
               if (b == abort_code) begin
                  phase_in = ST_ABORTED; code_in = RSP_OK;
               end else if (b == data_code) fcmd_in = FC_DATA;
               else if (b == end_code) fcmd_in = FC_END;
               else fcmd_in = FC_UNKNOWN;
            end else if (fcmd_ff == FC_DATA) begin
               pos_in = pos_ff + 9'd1;
               if (pos_ff == 9'd1) begin
                  flen_in = b; lok_in = len_good;
               end
               if (wr_store) fcrc_in = fcrc_ff ^ {24'd0, b};
               code_in = sts.data_ok ? RSP_OK : RSP_LEN;
            end else if (fcmd_ff == FC_END) begin
               pos_in = pos_ff + 9'd1;
               endf_in = endf_ff | ({56'd0, b} << {pos_ff[2:0] - 3'd1, 3'b000});
               if (done_end) begin
                  hcrc = endf_in[31:0];
                  hsize = endf_in[63:32];
                  if (total_ff != hsize) begin
                     phase_in = ST_FAILED; code_in = RSP_SIZE;
                  end else if (~ccrc_ff == hcrc) begin
                     phase_in = ST_SUCCESS; code_in = RSP_DONE;
                  end else begin
                     phase_in = ST_FAILED; code_in = RSP_CRC;
                  end
               end
            end
         end
      end
      // one crc bit per cycle
      if (cmd.crc_step) begin
         fcrc_in = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      if (cmd.drain_next) drn_in = drn_ff + WA'(1);
      if (cmd.commit) begin
         addr_in = addr_ff + {24'd0, flen_ff};
         total_in = total_ff + {24'd0, flen_ff};
         ccrc_in = fcrc_ff;
      end
      if (cmd.finish) begin
         pos_in = 9'd0; fcmd_in = FC_NONE; flen_in = 8'd0; lok_in = 1'b0;
         endf_in = 64'd0; fcrc_in = cmd.commit ? fcrc_ff : ccrc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ST_IDLE; pos_ff <= 9'd0; fcmd_ff <= FC_NONE; flen_ff <= 8'd0;
         lok_ff <= 1'b0; endf_ff <= 64'd0; addr_ff <= BASE_DEF; total_ff <= 32'd0;
         ccrc_ff <= CRC_INIT; fcrc_ff <= CRC_INIT; tcnt_ff <= 4'd0;
         drn_ff <= '0; code_ff <= RSP_OK;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; fcmd_ff <= fcmd_in; flen_ff <= flen_in;
         lok_ff <= lok_in; endf_ff <= endf_in; addr_ff <= addr_in; total_ff <= total_in;
         ccrc_ff <= ccrc_in; fcrc_ff <= fcrc_in; tcnt_ff <= tcnt_in;
         drn_ff <= drn_in; code_ff <= code_in;
      end
   end

   // payload word store, byte lanes merged on write
   always_ff @(posedge clock) begin
      if (cmd.take && wr_store) begin
         case (p2[1:0])
            2'd0: store[wsel] <= {24'd0, b};
            2'd1: store[wsel][15:8] <= b;
            2'd2: store[wsel][23:16] <= b;
            default: store[wsel][31:24] <= b;
         endcase
      end
   end

   // registered read of the word being drained
   always_ff @(posedge clock) begin
      wword_ff <= store[drn_in];
   end

   assign o_write_address  = addr_ff + {{(30 - WA){1'b0}}, drn_ff, 2'b00};
   assign o_write_word     = wword_ff;
   assign o_response_code  = code_ff;
   assign o_session_status = phase_ff;

endmodule

@@ hw/rtl/fufr_ctrl.sv @@
// fufr_ctrl: sequencer for byte steps, crc bits, word drain and response
// depends on fufr_pkg
module fufr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              o_is_write,
   output logic              o_is_resp,
   output logic              o_last,
   input  fufr_pkg::sts_type sts,
   output fufr_pkg::cmd_type cmd
);
   import fufr_pkg::*;

   fsm_type    state_ff, state_in;
   logic [2:0] bit_ff, bit_in;
   logic       need_ff, need_in;   // a result follows the crc
   logic       ok_ff, ok_in;
   logic       resp_is_ff, resp_is_in;
   logic       xfer;

   assign xfer = rsp_valid && !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff; bit_in = bit_ff; need_in = need_ff; ok_in = ok_ff;
      resp_is_in = resp_is_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               need_in = sts.frame_done || sts.quiet;
               ok_in = sts.data_ok;
               resp_is_in = sts.frame_done;
               bit_in = 3'd0;
               if (sts.need_crc) state_in = FSM_CRC;
               else if (sts.data_ok) state_in = FSM_DRAIN;
               else if (!sts.silent) state_in = FSM_RESP;
            end
         end
         FSM_CRC: begin
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               if (ok_ff) state_in = FSM_DRAIN;
               else if (need_ff) state_in = FSM_RESP;
               else state_in = FSM_IDLE;
            end
         end
         FSM_DRAIN: if (xfer && !sts.words_left) state_in = FSM_RESP;
         FSM_RESP: if (xfer) state_in = FSM_IDLE;
         default: state_in = FSM_IDLE;
      endcase
   end

   // outputs and commands
   always_comb begin
      cmd = '0;
      req_stall = (state_ff != FSM_IDLE);
      rsp_valid = 1'b0; o_is_write = 1'b0; o_is_resp = 1'b0; o_last = 1'b0;
      case (state_ff)
         FSM_IDLE: cmd.take = req_valid;
         FSM_CRC: cmd.crc_step = 1'b1;
         FSM_DRAIN: begin
            rsp_valid = 1'b1; o_is_write = 1'b1;
            cmd.drain_next = xfer && sts.words_left;
         end
         FSM_RESP: begin
            rsp_valid = 1'b1; o_is_resp = resp_is_ff; o_last = 1'b1;
            cmd.commit = xfer && ok_ff;
            cmd.finish = xfer;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE; bit_ff <= 3'd0; need_ff <= 1'b0; ok_ff <= 1'b0;
         resp_is_ff <= 1'b0;
      end else begin
         state_ff <= state_in; bit_ff <= bit_in; need_ff <= need_in; ok_ff <= ok_in;
         resp_is_ff <= resp_is_in;
      end
   end

endmodule

@@ test/tb_firmware_upgrade_frame_receiver.sv @@
// testbench for the firmware upgrade frame receiver: directed and random frames
// depends on fufr_pkg and firmware_upgrade_frame_receiver
module tb_firmware_upgrade_frame_receiver;
   import fufr_pkg::*;

   localparam int unsigned PBYTES = 128;
   localparam int unsigned SWORDS = PBYTES / 4;
   localparam int unsigned WD_LIMIT = 4000;

   typedef struct {
      bit        wv;
      bit [31:0] addr;
      bit [31:0] word;
      bit        rv;
      bit [2:0]  code;
      bit [2:0]  status;
      bit        last;
   } beat_type;

   int errors = 0;

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   // frame parser model and queue of pending beats
   class receiver_board;
      bit [7:0]  data_code, end_code, abort_code;
      bit [31:0] base;
      bit [3:0]  to_limit;
      status_type phase;
      bit [8:0]  fpos;
      fcmd_type  fcmd;
      bit [7:0]  flen;
      bit        len_ok;
      bit [31:0] store [SWORDS];
      bit [63:0] end_f;
      bit [31:0] waddr, total, ccrc, fcrc;
      bit [3:0]  to_cnt;
      beat_type  pending[$];

      function new();
         data_code = 1; end_code = 2; abort_code = 3;
         base = BASE_DEF; to_limit = 10;
         phase = ST_IDLE; waddr = base; total = 0; ccrc = CRC_INIT; to_cnt = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         fpos = 0; fcmd = FC_NONE; flen = 0; len_ok = 0; end_f = 0; fcrc = ccrc;
      endfunction

      function void push(bit wv, bit [31:0] a, bit [31:0] w, bit rv, bit [2:0] c, bit l);
         beat_type b;
         b.wv = wv; b.addr = a; b.word = w; b.rv = rv; b.code = c;
         b.status = phase; b.last = l;
         pending.push_back(b);
      endfunction

      function bit [31:0] crc8(bit [31:0] c, bit [7:0] b);
         c ^= {24'd0, b};
         for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         return c;
      endfunction

      function void set_reg(bit [2:0] idx, bit [31:0] v);
         case (idx)
            REG_DATA_CODE:  data_code = v[7:0];
            REG_END_CODE:   end_code = v[7:0];
            REG_ABORT_CODE: abort_code = v[7:0];
            REG_BASE:       base = v;
            REG_TIMEOUT:    to_limit = v[3:0];
            default: ;
         endcase
      endfunction

      // note one accepted input item
      function void note_item(bit [1:0] kind, bit [7:0] b);
         bit [31:0] p;
         if (kind == KIND_START) begin
            phase = ST_RECV; waddr = base; total = 0; ccrc = CRC_INIT; to_cnt = 0;
            clear_frame();
            return;
         end
         if (phase != ST_RECV) return;
         if (kind == KIND_TIMEOUT) begin
            clear_frame();
            to_cnt = to_cnt + 4'd1;
            if (to_cnt >= to_limit) begin
               phase = ST_TIMEDOUT;
               push(0, 0, 0, 0, RSP_OK, 1);
            end
            return;
         end
         if (kind != KIND_BYTE) return;
         if (fpos == 0) begin
            fpos = 1;
            if (b == abort_code) begin
               phase = ST_ABORTED;
               push(0, 0, 0, 1, RSP_OK, 1);
               return;
            end
            if (b == data_code) fcmd = FC_DATA;
            else if (b == end_code) fcmd = FC_END;
            else fcmd = FC_UNKNOWN;
            fcrc = ccrc;
            return;
         end
         if (fcmd == FC_DATA) begin
            if (fpos == 1) begin
               flen = b;
               len_ok = (b != 0) && (b <= PBYTES) && (b[1:0] == 0);
            end else begin
               p = 32'(fpos) - 32'd2;
               if (len_ok && (p >> 2) < SWORDS) begin
                  if (p[1:0] == 0) store[p >> 2] = 0;
                  store[p >> 2] |= 32'(b) << (p[1:0] * 8);
                  fcrc = crc8(fcrc, b);
               end
            end
            fpos++;
            if (fpos >= flen + 2) begin
               if (!len_ok) push(0, 0, 0, 1, RSP_LEN, 1);
               else begin
                  for (int i = 0; i < flen / 4 && i < SWORDS; i++)
                     push(1, waddr + 32'(4 * i), store[i], 0, RSP_OK, 0);
                  waddr += 32'(flen); total += 32'(flen); ccrc = fcrc;
                  push(0, 0, 0, 1, RSP_OK, 1);
               end
               clear_frame();
            end
            return;
         end
         if (fcmd == FC_END) begin
            end_f |= 64'(b) << ((fpos - 1) * 8);
            fpos++;
            if (fpos >= 9) begin
               if (total != end_f[63:32]) begin
                  phase = ST_FAILED; push(0, 0, 0, 1, RSP_SIZE, 1);
               end else if ((ccrc ^ CRC_INIT) == end_f[31:0]) begin
                  phase = ST_SUCCESS; push(0, 0, 0, 1, RSP_DONE, 1);
               end else begin
                  phase = ST_FAILED; push(0, 0, 0, 1, RSP_CRC, 1);
               end
               clear_frame();
            end
         end
      endfunction

      // compare one result transfer with the oldest pending beat
      task check_beat(beat_type g);
         beat_type w;
         if (pending.size() == 0) begin
            report("unexpected transfer", g.status, 0);
            return;
         end
         w = pending.pop_front();
         if (g.wv != w.wv) report("write_valid", g.wv, w.wv);
         if (g.addr != w.addr) report("write_address", g.addr, w.addr);
         if (g.word != w.word) report("write_word", g.word, w.word);
         if (g.rv != w.rv) report("response_valid", g.rv, w.rv);
         if (g.code != w.code) report("response_code", g.code, w.code);
         if (g.status != w.status) report("session_status", g.status, w.status);
         if (g.last != w.last) report("last", g.last, w.last);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [1:0] req_kind = 0;
   logic [7:0] req_rx_byte = 0;
   logic rsp_valid, rsp_stall = 0;
   logic rsp_write_valid, rsp_response_valid, rsp_last;
   logic [31:0] rsp_write_address, rsp_write_word;
   logic [2:0] rsp_response_code, rsp_session_status;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0, csr_prdata;
   logic csr_pready;

   firmware_upgrade_frame_receiver dut (.*);

   receiver_board board = new();
   int n_items = 0, n_beats = 0, idle_cycles = 0;
   bit stim_done = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // result side: random stall, check every transfer
   initial begin
      int gap;
      beat_type g;
      forever begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
         @(negedge clock);
         rsp_stall = (gap != 0);
         repeat (gap) @(negedge clock);
         rsp_stall = 0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         g.wv = rsp_write_valid; g.addr = rsp_write_address; g.word = rsp_write_word;
         g.rv = rsp_response_valid; g.code = rsp_response_code;
         g.status = rsp_session_status; g.last = rsp_last;
         board.check_beat(g);
         n_beats++;
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("watchdog expired, %0d beats pending", board.pending.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic csr_write(bit [2:0] idx, bit [31:0] v);
      @(negedge clock);
      csr_psel = 1; csr_penable = 0; csr_pwrite = 1; csr_paddr = {idx, 2'b00};
      csr_pwdata = v;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      board.set_reg(idx, v);
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
   endtask

   task automatic send(bit [1:0] kind, bit [7:0] b);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 0;
      end
      @(negedge clock);
      req_valid = 1; req_kind = kind; req_rx_byte = b;
      do @(posedge clock); while (req_stall);
      board.note_item(kind, b);
      n_items++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic send_byte(bit [7:0] b);
      send(KIND_BYTE, b);
   endtask

   // data frame with given length, random payload
   task automatic data_frame(bit [7:0] len);
      send_byte(board.data_code);
      send_byte(len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom));
   endtask

   // end frame; good selects the matching crc and size
   task automatic end_frame(bit good);
      bit [31:0] c, s;
      c = good ? ~board.ccrc : $urandom;
      s = good ? board.total : ($urandom_range(0, 1) ? board.total : $urandom);
      send_byte(board.end_code);
      for (int i = 0; i < 4; i++) send_byte(c[8 * i +: 8]);
      for (int i = 0; i < 4; i++) send_byte(s[8 * i +: 8]);
   endtask

   task automatic quiesce();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic random_session();
      int frames, sel;
      send(KIND_START, 8'($urandom));
      frames = $urandom_range(1, 4);
      for (int f = 0; f < frames; f++) begin
         sel = $urandom_range(0, 19);
         if (sel < 12) data_frame(8'(4 * $urandom_range(1, 4)));
         else if (sel < 14) data_frame(8'($urandom_range(0, 11)));
         else if (sel < 15) send(KIND_TIMEOUT, 8'($urandom));
         else if (sel < 16) begin
            send_byte(8'($urandom)); send_byte(8'($urandom)); send(KIND_TIMEOUT, 8'd0);
         end else if (sel < 17) send(2'd3, 8'($urandom));
         else if (sel < 18) begin
            send_byte(board.data_code); send_byte(8'd8); send_byte(8'($urandom));
            send(KIND_TIMEOUT, 8'd0);
         end else data_frame(8'(4 * $urandom_range(1, 3)));
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) end_frame(1);
      else if (sel < 8) end_frame(0);
      else if (sel < 9) send_byte(board.abort_code);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: defaults, extremes of length and end
      send_byte(8'h55);
      send(KIND_TIMEOUT, 8'hff);
      send(KIND_START, 8'h00);
      data_frame(8'd4);
      data_frame(8'd0);
      data_frame(8'd6);
      send(2'd3, 8'hff);
      end_frame(1);
      send_byte(8'h01);
      quiesce();

      // register extremes, longest frame, timeouts to the limit
      csr_write(REG_DATA_CODE, 32'hff);
      csr_write(REG_END_CODE, 32'h00);
      csr_write(REG_ABORT_CODE, 32'h80);
      csr_write(REG_BASE, 32'hffff_fff8);
      csr_write(REG_TIMEOUT, 32'd1);
      send(KIND_START, 8'd0);
      data_frame(8'(PBYTES));
      data_frame(8'd132);
      send(KIND_TIMEOUT, 8'd0);
      send(KIND_START, 8'd0);
      send_byte(8'h80);
      quiesce();

      // command code clash with limit 0 and unknown frame
      csr_write(REG_DATA_CODE, 32'h80);
      csr_write(REG_END_CODE, 32'h80);
      csr_write(REG_TIMEOUT, 32'd0);
      send(KIND_START, 8'd0);
      send_byte(8'h80);
      send(KIND_START, 8'd0);
      send_byte(8'h11);
      send_byte(8'h22);
      send(KIND_TIMEOUT, 8'd0);
      quiesce();

      // random phases with random register settings
      while (n_items < 330) begin
         csr_write(REG_DATA_CODE, $urandom);
         csr_write(REG_END_CODE, $urandom);
         csr_write(REG_ABORT_CODE, $urandom);
         csr_write(REG_BASE, $urandom);
         csr_write(REG_TIMEOUT, 32'($urandom_range(0, 15)));
         random_session();
         quiesce();
      end
      csr_write(REG_DATA_CODE, 32'd1);
      csr_write(REG_END_CODE, 32'd2);
      csr_write(REG_ABORT_CODE, 32'd3);
      csr_write(REG_BASE, 32'd0);
      csr_write(REG_TIMEOUT, 32'd15);
      random_session();
      quiesce();

      $display("covered %0d input items and %0d result transfers", n_items, n_beats);
      if (errors == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d beats left", errors, board.pending.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
